// ----- hw/rtl/mrcc_pkg.sv -----
`timescale 1ns / 1ps
package mrcc_pkg;

  // shared divider: 64-bit magnitude with 31 extra fraction bits over a 64-bit divisor
  localparam int DIV_NW = 95;
  localparam int DIV_DW = 64;

  // sample and mean-removed value widths
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 10;
  localparam int MEAN_W   = 27;
  localparam int DIFF_W   = 28;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int ACC_W    = 64;
  localparam int ROOT_W   = 32;

  // register map
  localparam logic REG_LAG_LIMIT = 1'b0;
  localparam logic REG_NORMALIZE = 1'b1;

endpackage

// ----- hw/rtl/mrcc_store.sv -----
`timescale 1ns / 1ps
module mrcc_store
  import mrcc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [SAMPLE_W-1:0] wr_a,
  input  logic [SAMPLE_W-1:0] wr_b,
  input  logic [AW-1:0]       rd_addr_a,
  input  logic [AW-1:0]       rd_addr_b,
  output logic [SAMPLE_W-1:0] rd_a,
  output logic [SAMPLE_W-1:0] rd_b
);

  logic [SAMPLE_W-1:0] mem_a [DEPTH];
  logic [SAMPLE_W-1:0] mem_b [DEPTH];

  // one write port, one registered read port per sequence
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
    rd_a <= mem_a[rd_addr_a];
    rd_b <= mem_b[rd_addr_b];
  end

endmodule

// ----- hw/rtl/mrcc_div.sv -----
`timescale 1ns / 1ps
module mrcc_div
  import mrcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo,
  output logic              rem_nz
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   trial;
  logic              take;

  // one restoring step: bring down the next numerator bit
  assign shifted = {rem, quo[DIV_NW-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign take    = (shifted >= {1'b0, dsr});
  assign rem_nz  = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DIV_NW);
        quo <= num;
        dsr <= den;
        rem <= '0;
      end else if (run) begin
        rem <= take ? trial[DIV_DW-1:0] : shifted[DIV_DW-1:0];
        quo <= {quo[DIV_NW-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/mrcc_isqrt.sv -----
`timescale 1ns / 1ps
module mrcc_isqrt
  import mrcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       val,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic        run;
  logic [4:0]  cnt;
  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bit_r;
  logic [64:0] trial;
  logic        take;

  // two radicand bits per step, floor square root
  assign trial = {1'b0, res} + {1'b0, bit_r};
  assign take  = ({1'b0, rem} >= trial);
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= 5'd31;
        rem   <= val;
        res   <= '0;
        bit_r <= 64'd1 << 62;
      end else if (run) begin
        if (take) begin
          rem <= rem - trial[63:0];
          res <= (res >> 1) + bit_r;
        end else begin
          res <= res >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt   <= cnt - 1'b1;
        if (cnt == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/mean_removed_cross_correlator.sv -----
`timescale 1ns / 1ps
// Mean-removed cross-correlator. Sample pairs are taken one per cycle while busy is low and
// written into two sample memories while they have room; a pair marked final_pair starts the
// correlation pass and raises busy. With n stored pairs and L lags a side, the pass computes
// the two means (bit-serial divider), the variances and the two square roots, then for each
// lag k runs the n-|k| products through the memory read pipeline, plus a divider pass per lag
// when normalize_enable is set and the denominator is nonzero. Each result appears for exactly
// one cycle with result_valid high and must be taken then; results for lags -L..+L come in
// order, the last one with run_end set. Configuration may be written only while busy is low.
module mean_removed_cross_correlator
  import mrcc_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int MAX_LAG     = 31
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [15:0]         sample_a,
  input  logic signed [15:0]         sample_b,
  input  logic                       final_pair,
  output logic                       result_valid,
  output logic signed [5:0]          lag_value,
  output logic signed [63:0]         corr_value,
  output logic                       run_end,
  output logic                       dropped_flag,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SW   = SAMPLE_W + CW;
  localparam int NUMW = SW + 12;
  localparam int IW   = CW + 7;

  typedef enum logic [3:0] {
    S_LOAD, S_MEAN_A, S_MEAN_AW, S_MEAN_B, S_MEAN_BW, S_VAR_INIT, S_VAR,
    S_SQRT_A, S_SQRT_AW, S_SQRT_B, S_SQRT_BW, S_DEN, S_LAG_INIT, S_LAG, S_POST, S_NDIV
  } state_t;

  state_t state;

  // configuration
  logic signed [5:0] lag_limit;
  logic              normalize_enable;

  // load state
  logic [CW-1:0]        pair_count;
  logic signed [SW-1:0] sum_a;
  logic signed [SW-1:0] sum_b;
  logic                 overflow_seen;

  // pass state
  logic signed [MEAN_W-1:0] m_a;
  logic signed [MEAN_W-1:0] m_b;
  logic                     mean_neg;
  logic [63:0]              var_a;
  logic [63:0]              var_b;
  logic [ROOT_W-1:0]        root_a;
  logic [63:0]              den_r;
  logic [4:0]               lag_l;
  logic signed [5:0]        k;
  logic [AW-1:0]            idx;
  logic [AW-1:0]            iend;
  logic signed [5:0]        koff;
  logic                     issuing;
  logic signed [ACC_W-1:0]  acc;

  // read pipeline
  logic                     v1, v2, v3;
  logic                     l1, l2, l3;
  logic signed [DIFF_W-1:0] da, db;
  logic signed [PROD_W-1:0] p1, p2;

  logic               accept;
  logic               room;
  logic               cfg_write;
  logic [SAMPLE_W-1:0] rd_a, rd_b;
  logic [AW-1:0]      raddr_b;

  assign accept    = start && !busy;
  assign busy      = (state != S_LOAD);
  assign room      = (pair_count < CW'(MAX_SAMPLES));
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // register read-back
  always_comb begin
    case (paddr[2])
      REG_LAG_LIMIT: prdata = {{26{lag_limit[5]}}, lag_limit};
      REG_NORMALIZE: prdata = {31'd0, normalize_enable};
      default:       prdata = '0;
    endcase
  end

  // sample memories
  assign raddr_b = idx + AW'($unsigned(IW'(koff)));

  mrcc_store #(.DEPTH(MAX_SAMPLES), .AW(AW)) u_store (
    .clk       (clk),
    .wr_en     (accept && room),
    .wr_addr   (pair_count[AW-1:0]),
    .wr_a      (sample_a),
    .wr_b      (sample_b),
    .rd_addr_a (idx),
    .rd_addr_b (raddr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // mean numerator: 2048*sum + n over 2n
  logic signed [NUMW-1:0] mean_num;
  logic [NUMW-1:0]        mean_mag;
  assign mean_num = ((state == S_MEAN_A) ? NUMW'(sum_a) : NUMW'(sum_b)) * NUMW'(2048)
                    + NUMW'({1'b0, pair_count});
  assign mean_mag = mean_num[NUMW-1] ? NUMW'(-mean_num) : NUMW'(mean_num);

  // magnitude of the lag sum
  logic [63:0] acc_mag;
  assign acc_mag = acc[63] ? 64'(-acc) : 64'(acc);

  // shared divider
  logic              div_start, div_done, div_rnz;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic              norm_go;

  assign norm_go   = normalize_enable && (den_r != '0);
  assign div_start = (state == S_MEAN_A) || (state == S_MEAN_B) ||
                     ((state == S_POST) && norm_go);
  always_comb begin
    if (state == S_POST) begin
      div_num = {acc_mag, 31'd0};
      div_den = den_r;
    end else begin
      div_num = DIV_NW'(mean_mag);
      div_den = DIV_DW'({pair_count, 1'b0});
    end
  end

  mrcc_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done   (div_done),
    .quo    (div_quo),
    .rem_nz (div_rnz)
  );

  // floor division result for a signed numerator
  logic signed [MEAN_W-1:0] mean_res;
  logic [MEAN_W-1:0]        mean_up;
  assign mean_up  = div_quo[MEAN_W-1:0] + MEAN_W'(div_rnz);
  assign mean_res = mean_neg ? -$signed(mean_up) : $signed(div_quo[MEAN_W-1:0]);

  // square root unit, used for both variances
  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;
  assign sq_start = (state == S_SQRT_A) || (state == S_SQRT_B);

  mrcc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .val   ((state == S_SQRT_A) ? var_a : var_b),
    .done  (sq_done),
    .root  (sq_root)
  );

  // lag count and index range of the next lag
  logic [CW-1:0]        lim;
  logic [4:0]           cap;
  logic [4:0]           lag_pick;
  logic signed [IW-1:0] kx;
  logic [AW-1:0]        i_start, i_end;
  assign lim      = pair_count - 1'b1;
  assign cap      = (lim > CW'(MAX_LAG)) ? 5'(MAX_LAG) : 5'(lim);
  assign lag_pick = (lag_limit < 0 || 5'(lag_limit) > cap) ? cap : 5'(lag_limit);
  assign kx       = IW'(k);
  assign i_start  = (kx < 0) ? AW'(-kx) : '0;
  assign i_end    = (kx > 0) ? AW'($signed(IW'({1'b0, lim})) - kx) : AW'(lim);

  // raw rounding: divide by 16, ties up, clamped at the top
  logic [64:0]       rnd;
  logic signed [63:0] raw_val;
  assign rnd     = {acc[63], acc} + 65'd8;
  assign raw_val = (!rnd[64] && rnd[63]) ? (acc >>> 4) : {{4{rnd[63]}}, rnd[63:4]};

  // normalized rounding and saturation
  logic [63:0]        nq;
  logic signed [63:0] norm_val;
  assign nq       = (div_quo[DIV_NW-1:63] != '0) ? (64'd1 << 62)
                  : 64'(({1'b0, div_quo[62:0]} + 64'd1) >> 1);
  assign norm_val = acc[63] ? -$signed(nq) : $signed(nq);

  // pipeline arithmetic
  logic [64:0] va_sum, vb_sum, acc_sum;
  assign va_sum  = {1'b0, var_a} + {9'd0, p1};
  assign vb_sum  = {1'b0, var_b} + {9'd0, p2};
  assign acc_sum = {acc[63], acc} + {{9{p1[PROD_W-1]}}, p1};

  // read pipeline: memory data, mean removal, products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issuing && ((state == S_VAR) || (state == S_LAG));
      v2 <= v1;
      v3 <= v2;
    end
    l1 <= (idx == iend);
    l2 <= l1;
    l3 <= l2;
    da <= DIFF_W'($signed({rd_a, 10'd0})) - DIFF_W'(m_a);
    db <= DIFF_W'($signed({rd_b, 10'd0})) - DIFF_W'(m_b);
    p1 <= da * ((state == S_VAR) ? da : db);
    p2 <= db * db;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_LOAD;
      lag_limit        <= -6'sd1;
      normalize_enable <= 1'b0;
      pair_count       <= '0;
      sum_a            <= '0;
      sum_b            <= '0;
      overflow_seen    <= 1'b0;
      issuing          <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_write) begin
        case (paddr[2])
          REG_LAG_LIMIT: lag_limit <= $signed(pwdata[5:0]);
          REG_NORMALIZE: normalize_enable <= pwdata[0];
          default: ;
        endcase
      end
      if (issuing) begin
        idx <= idx + 1'b1;
        if (idx == iend) issuing <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              pair_count <= pair_count + 1'b1;
              sum_a      <= sum_a + SW'(sample_a);
              sum_b      <= sum_b + SW'(sample_b);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (final_pair) state <= S_MEAN_A;
          end
        end
        S_MEAN_A: begin
          mean_neg <= mean_num[NUMW-1];
          state    <= S_MEAN_AW;
        end
        S_MEAN_AW: begin
          if (div_done) begin
            m_a   <= mean_res;
            state <= S_MEAN_B;
          end
        end
        S_MEAN_B: begin
          mean_neg <= mean_num[NUMW-1];
          state    <= S_MEAN_BW;
        end
        S_MEAN_BW: begin
          if (div_done) begin
            m_b   <= mean_res;
            state <= S_VAR_INIT;
          end
        end
        S_VAR_INIT: begin
          idx     <= '0;
          iend    <= AW'(lim);
          koff    <= '0;
          issuing <= 1'b1;
          var_a   <= '0;
          var_b   <= '0;
          state   <= S_VAR;
        end
        S_VAR: begin
          if (v3) begin
            var_a <= va_sum[64] ? '1 : va_sum[63:0];
            var_b <= vb_sum[64] ? '1 : vb_sum[63:0];
            if (l3) state <= S_SQRT_A;
          end
        end
        S_SQRT_A: state <= S_SQRT_AW;
        S_SQRT_AW: begin
          if (sq_done) begin
            root_a <= sq_root;
            state  <= S_SQRT_B;
          end
        end
        S_SQRT_B: state <= S_SQRT_BW;
        S_SQRT_BW: begin
          if (sq_done) begin
            den_r <= 64'(root_a) * 64'(sq_root);
            state <= S_DEN;
          end
        end
        S_DEN: begin
          lag_l <= lag_pick;
          k     <= -$signed({1'b0, lag_pick});
          state <= S_LAG_INIT;
        end
        S_LAG_INIT: begin
          idx     <= i_start;
          iend    <= i_end;
          koff    <= k;
          issuing <= 1'b1;
          acc     <= '0;
          state   <= S_LAG;
        end
        S_LAG: begin
          if (v3) begin
            if (acc_sum[64] != acc_sum[63]) begin
              acc <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
              acc <= acc_sum[63:0];
            end
            if (l3) state <= S_POST;
          end
        end
        S_POST, S_NDIV: begin
          if ((state == S_POST && !norm_go) || (state == S_NDIV && div_done)) begin
            result_valid <= 1'b1;
            lag_value    <= k;
            run_end      <= (k == $signed({1'b0, lag_l}));
            dropped_flag <= overflow_seen;
            if (state == S_NDIV) begin
              corr_value <= norm_val;
            end else begin
              corr_value <= normalize_enable ? 64'sd0 : raw_val;
            end
            if (k == $signed({1'b0, lag_l})) begin
              pair_count    <= '0;
              sum_a         <= '0;
              sum_b         <= '0;
              overflow_seen <= 1'b0;
              state         <= S_LOAD;
            end else begin
              k     <= k + 6'sd1;
              state <= S_LAG_INIT;
            end
          end else if (state == S_POST) begin
            state <= S_NDIV;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // results never come in two adjacent cycles
  assert property (@(posedge clk) disable iff (rst) result_valid |=> !result_valid)
    else $error("back-to-back result strobes");
  // a final pair always starts the pass
  assert property (@(posedge clk) disable iff (rst) (accept && final_pair) |=> busy)
    else $error("final pair did not start the pass");
  // the fill count never passes the memory depth
  assert property (@(posedge clk) disable iff (rst) pair_count <= CW'(MAX_SAMPLES))
    else $error("pair count beyond store depth");
  // the last result returns the block to loading
  assert property (@(posedge clk) disable iff (rst) (result_valid && run_end) |-> !busy)
    else $error("still busy after the last result");
`endif

endmodule
